/* sv/clipped_state_variable_filter_assert.svh */
// Assertion macros for the clipped state variable filter checker.
// Needs nothing but a clock named clk and a reset named rst where it is used.
`ifndef CLIPPED_STATE_VARIABLE_FILTER_ASSERT_SVH
`define CLIPPED_STATE_VARIABLE_FILTER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define CSVF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CSVF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/csvf_pkg.sv */
// Shared constants and controller/datapath interface types for the
// clipped state variable filter. No dependencies.
`default_nettype none

package csvf_pkg;

  localparam int SAMPLE_W      = 8;
  localparam int COEF_W        = 16;
  localparam int COEF_SHIFT    = 15;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [COEF_W-1:0] COEF_RESET = 16'd3277;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take an input word and form the high value
    logic step_band;  // band += high * coefficient
    logic step_low;   // low += band * coefficient
    logic push;       // load the output register
  } csvf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;       // the word in progress asks for a result
    logic out_free;   // the output register can take a word this cycle
  } csvf_stat_t;

endpackage

`default_nettype wire

/* sv/csvf_ctrl.sv */
// Sequencing state machine of the clipped state variable filter.
// Depends on csvf_pkg for the command and status types.
`default_nettype none

module csvf_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire csvf_pkg::csvf_stat_t stat,
  output csvf_pkg::csvf_cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BAND = 2'd1;
  localparam logic [1:0] ST_LOW  = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_BAND;
        end
      end
      ST_BAND: begin
        cmd.step_band = 1'b1;
        state_next    = ST_LOW;
      end
      ST_LOW: begin
        cmd.step_low = 1'b1;
        state_next   = stat.emit ? ST_PUSH : ST_IDLE;
      end
      ST_PUSH: begin
        // Hold here until the previous result has left the output register.
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* sv/csvf_datapath.sv */
// Datapath of the clipped state variable filter: integrators, coefficient
// register, one shared multiplier, clipping and the output register.
// Depends on csvf_pkg for constants and the command and status types.
`default_nettype none

module csvf_datapath #(
  parameter int FRAC_BITS = csvf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [csvf_pkg::COEF_W-1:0]     cfg_data,
  input  wire logic [csvf_pkg::SAMPLE_W-1:0]   sample,
  input  wire logic                            start_req,
  input  wire logic                            emit,
  input  wire csvf_pkg::csvf_cmd_t             cmd,
  output csvf_pkg::csvf_stat_t                 stat,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [2*csvf_pkg::SAMPLE_W-1:0]      m_tdata
);

  localparam int SW = csvf_pkg::SAMPLE_W;
  localparam int CW = csvf_pkg::COEF_W;
  localparam int W  = SW + FRAC_BITS;   // signal value width
  localparam int PW = W + CW + 1;       // signed product width
  localparam int EW = W + CW + 2;       // working width for sums

  localparam logic signed [EW-1:0] CLIP_HI = EW'(127) <<< FRAC_BITS;
  localparam logic signed [EW-1:0] CLIP_LO = -(EW'(128) <<< FRAC_BITS);

  logic [CW-1:0]        coef;
  logic signed [W-1:0]  band;
  logic signed [W-1:0]  low;
  logic signed [W-1:0]  high;
  logic                 emit_reg;

  logic signed [W-1:0]  band_in;
  logic signed [W-1:0]  low_in;
  logic signed [EW-1:0] high_raw;
  logic signed [W-1:0]  mul_a;
  logic signed [PW-1:0] prod;
  logic signed [EW-1:0] scaled;
  logic signed [W-1:0]  acc;
  logic signed [EW-1:0] acc_sum;
  logic signed [W-1:0]  acc_clip;
  logic [SW-1:0]        low_q;
  logic [SW-1:0]        high_q;

  function automatic logic signed [W-1:0] clip(input logic signed [EW-1:0] v);
    if (v > CLIP_HI) begin
      clip = CLIP_HI[W-1:0];
    end else if (v < CLIP_LO) begin
      clip = CLIP_LO[W-1:0];
    end else begin
      clip = v[W-1:0];
    end
  endfunction

  // Integer part with truncation toward zero: floor, plus one when the value
  // is negative and has fraction bits set.
  function automatic logic [SW-1:0] to_int(input logic signed [W-1:0] v);
    to_int = v[W-1:FRAC_BITS] + SW'(v[W-1] & (|v[FRAC_BITS-1:0]));
  endfunction

  // A start word sees both integrators as zero.
  assign band_in  = start_req ? '0 : band;
  assign low_in   = start_req ? '0 : low;
  assign high_raw = (EW'($signed(sample)) <<< FRAC_BITS) - EW'(band_in) - EW'(low_in);

  // One multiplier serves both updates; the shift floors the product.
  assign mul_a    = cmd.step_low ? band : high;
  assign prod     = PW'(mul_a) * PW'($signed({1'b0, coef}));
  assign scaled   = EW'(prod) >>> csvf_pkg::COEF_SHIFT;
  assign acc      = cmd.step_low ? low : band;
  assign acc_sum  = EW'(acc) + scaled;
  assign acc_clip = clip(acc_sum);

  assign low_q  = to_int(low);
  assign high_q = to_int(high);

  assign stat.emit     = emit_reg;
  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= csvf_pkg::COEF_RESET;
    end else if (cfg_we) begin
      coef <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band <= '0;
      low  <= '0;
    end else begin
      if (cmd.load) begin
        band <= band_in;
        low  <= low_in;
      end else if (cmd.step_band) begin
        band <= acc_clip;
      end else if (cmd.step_low) begin
        low <= acc_clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      high     <= clip(high_raw);
      emit_reg <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      m_tdata <= {high_q, low_q};
    end
  end

endmodule

`default_nettype wire

/* sv/clipped_state_variable_filter.sv */
// Clipped state variable filter. Each input word carries one signed 8-bit
// sample; the filter forms high = sample - band - low, then updates band and
// low through the coefficient, clipping each value to [-128, 127]. A word
// with start_req set clears both integrators first, and a word with emit set
// yields one output word holding low and high truncated toward zero. After
// acceptance the controller runs the band and low updates and, with emit, the
// output push, which waits while the previous result sits unread in the output
// register; the order is set by the single shared multiplier doing the two
// dependent coefficient multiplies in turn. The coefficient (units of 1/32768)
// is written by the user through cfg_we/cfg_data only while idle; the block
// does not enforce this. Depends on csvf_pkg, csvf_ctrl and csvf_datapath.
`default_nettype none

module clipped_state_variable_filter #(
  parameter int FRAC_BITS = csvf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [csvf_pkg::COEF_W-1:0]  cfg_data,   // coefficient
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [7:0]                   s_tdata,    // [7:0] sample
  input  wire logic [1:0]                   s_tuser,    // [0] start_req, [1] emit
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [15:0]                       m_tdata     // [7:0] low_sample, [15:8] high_sample
);

  csvf_pkg::csvf_cmd_t  cmd;
  csvf_pkg::csvf_stat_t stat;

  csvf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  csvf_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .sample    (s_tdata),
    .start_req (s_tuser[0]),
    .emit      (s_tuser[1]),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

/* sv/csvf_checker.sv */
// Port-level checks for the clipped state variable filter, bound to the top.
// Depends on clipped_state_variable_filter_assert.svh.
`default_nettype none
`include "clipped_state_variable_filter_assert.svh"

module csvf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  // Out of reset the block is ready and holds no result.
  `CSVF_ASSERT_ALWAYS(a_reset_state, rst |=> (s_tready && !m_tvalid), "bad state after reset")

  // A stalled result word keeps its value.
  `CSVF_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "output word changed while stalled")

  // Every accepted word keeps the filter busy through its band and low steps.
  `CSVF_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready, "ready too soon after an accepted word")

  // A warm-up word never produces a result.
  `CSVF_ASSERT(a_warmup_silent, (s_tvalid && s_tready && !s_tuser[1]) |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid) ##1 !$rose(m_tvalid), "result from a warm-up word")

endmodule

bind clipped_state_variable_filter csvf_checker u_csvf_checker (.*);

`default_nettype wire
